// ===== src/serial_command_parser_defines.svh =====
// Assertion macros used by the checker file of the serial command parser.
`ifndef SERIAL_COMMAND_PARSER_DEFINES_SVH
`define SERIAL_COMMAND_PARSER_DEFINES_SVH

// Same-cycle implication, sampled on clk and switched off during rst.
`define SCP_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and switched off during rst.
`define SCP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/scp_pkg.sv =====
// Shared types, event codes, character constants and hex digit decoder of the serial command parser.
package scp_pkg;

  // Event codes carried on event_res.
  localparam logic [2:0] EV_NONE   = 3'd0;
  localparam logic [2:0] EV_BEGIN  = 3'd1;
  localparam logic [2:0] EV_DATA   = 3'd2;
  localparam logic [2:0] EV_COMMIT = 3'd3;
  localparam logic [2:0] EV_VOLT   = 3'd4;

  // Characters that steer the parser.
  localparam logic [7:0] CH_VOLT      = 8'h56;  // 'V'
  localparam logic [7:0] CH_PLAN      = 8'h57;  // 'W'
  localparam logic [7:0] CH_PLAN_LOGO = 8'h4C;  // 'L'
  localparam logic [7:0] CH_STAR      = 8'h2A;  // '*'
  localparam logic [7:0] CH_ZERO      = 8'h30;  // '0'
  localparam logic [7:0] CH_NINE      = 8'h39;  // '9'
  localparam logic [7:0] CH_UPPER_A   = 8'h41;  // 'A'
  localparam logic [7:0] CH_UPPER_F   = 8'h46;  // 'F'

  // A byte held in the input register, passed on to the parse stage.
  typedef struct packed {
    logic       valid;
    logic [7:0] data;
  } scp_stage_t;

  // Decoded hex digit: ok is low for anything but 0-9 and upper-case A-F.
  typedef struct packed {
    logic       ok;
    logic [3:0] value;
  } scp_hex_t;

  function automatic scp_hex_t hex_decode(input logic [7:0] c);
    scp_hex_t   res;
    logic [7:0] diff;
    res  = '0;
    diff = '0;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      diff      = c - CH_ZERO;
      res.ok    = 1'b1;
      res.value = diff[3:0];
    end else if (c >= CH_UPPER_A && c <= CH_UPPER_F) begin
      diff      = c - CH_UPPER_A + 8'd10;
      res.ok    = 1'b1;
      res.value = diff[3:0];
    end
    return res;
  endfunction

endpackage

// ===== src/scp_input_stage.sv =====
// Input register of the serial command parser, holding one received byte.
module scp_input_stage
  import scp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] rx_byte,
  input  logic       advance,
  output scp_stage_t stage
);

  logic       valid;
  logic [7:0] data;
  logic       free;

  // The register can take a byte when empty or when its byte moves on this cycle.
  assign free     = !valid || advance;
  assign in_stall = !free;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (free) begin
      valid <= in_valid;
    end
    if (free && in_valid) begin
      data <= rx_byte;
    end
  end

  assign stage.valid = valid;
  assign stage.data  = data;

endmodule

// ===== src/scp_parse.sv =====
// Parse stage: message state machine, checksum, voltage store and result register.
module scp_parse
  import scp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        logo_mode,
  input  scp_stage_t  stage,
  output logic        advance,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  event_res,
  output logic [7:0]  data_byte,
  output logic [15:0] voltage_value
);

  typedef enum logic [2:0] {
    PH_IDLE       = 3'd0,
    PH_VOLT_HIGH  = 3'd1,
    PH_VOLT_LOW   = 3'd2,
    PH_PLAN_DATA  = 3'd3,
    PH_PLAN_CHECK = 3'd4
  } phase_t;

  phase_t      phase, phase_next;
  logic        have_high, have_high_next;
  logic [3:0]  high_nibble, high_nibble_next;
  logic [7:0]  running_sum, running_sum_next;
  logic [7:0]  volt_high, volt_high_next;
  logic [15:0] stored_voltage, stored_voltage_next;
  logic [2:0]  ev_next;
  logic [7:0]  data_next;
  logic        out_free;
  logic        fire;
  logic [7:0]  plan_letter;
  logic [7:0]  c;
  scp_hex_t    hex;

  // The result register is free when empty or when its result is taken now.
  assign out_free = !out_valid || !out_stall;
  assign fire     = stage.valid && out_free;
  assign advance  = fire;

  assign c           = stage.data;
  assign hex         = hex_decode(c);
  assign plan_letter = logo_mode ? CH_PLAN_LOGO : CH_PLAN;

  // Next state and result for the byte in the input register.
  always_comb begin
    phase_next          = phase;
    have_high_next      = have_high;
    high_nibble_next    = high_nibble;
    running_sum_next    = running_sum;
    volt_high_next      = volt_high;
    stored_voltage_next = stored_voltage;
    ev_next             = EV_NONE;
    data_next           = '0;
    case (phase)
      PH_VOLT_HIGH: begin
        volt_high_next = c;
        phase_next     = PH_VOLT_LOW;
      end
      PH_VOLT_LOW: begin
        // Doubling with 16-bit wrap is a left shift dropping the top bit.
        stored_voltage_next = {volt_high[6:0], c, 1'b0};
        ev_next             = EV_VOLT;
        phase_next          = PH_IDLE;
      end
      PH_PLAN_DATA: begin
        if (c == CH_STAR) begin
          have_high_next = 1'b0;
          phase_next     = PH_PLAN_CHECK;
        end else if (!hex.ok) begin
          phase_next = PH_IDLE;
        end else begin
          if (!have_high) begin
            high_nibble_next = hex.value;
            have_high_next   = 1'b1;
          end else begin
            data_next      = {high_nibble, hex.value};
            ev_next        = EV_DATA;
            have_high_next = 1'b0;
          end
          running_sum_next = running_sum + c;
        end
      end
      PH_PLAN_CHECK: begin
        if (!hex.ok) begin
          phase_next = PH_IDLE;
        end else if (!have_high) begin
          high_nibble_next = hex.value;
          have_high_next   = 1'b1;
        end else begin
          if ({high_nibble, hex.value} == running_sum) begin
            ev_next = EV_COMMIT;
          end
          have_high_next = 1'b0;
          phase_next     = PH_IDLE;
        end
      end
      default: begin
        phase_next = PH_IDLE;
        if (c == CH_VOLT) begin
          phase_next = PH_VOLT_HIGH;
        end else if (c == plan_letter) begin
          have_high_next   = 1'b0;
          running_sum_next = '0;
          phase_next       = PH_PLAN_DATA;
          ev_next          = EV_BEGIN;
        end
      end
    endcase
  end

  // Parser state and result register, loaded at each byte transfer; the result valid clears once taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      have_high      <= 1'b0;
      high_nibble    <= '0;
      running_sum    <= '0;
      volt_high      <= '0;
      stored_voltage <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (fire) begin
        phase          <= phase_next;
        have_high      <= have_high_next;
        high_nibble    <= high_nibble_next;
        running_sum    <= running_sum_next;
        volt_high      <= volt_high_next;
        stored_voltage <= stored_voltage_next;
        out_valid      <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
    if (fire) begin
      event_res     <= ev_next;
      data_byte     <= data_next;
      voltage_value <= stored_voltage_next;
    end
  end

endmodule

// ===== src/serial_command_parser.sv =====
// Top level of the serial command parser: input register, parse stage, mode register.
//
// Every received byte produces exactly one result: the byte is held in the input
// register, then passes through the combinational parse logic into the result
// register. A new byte is taken in every cycle while the output is not stalled;
// throughput is one byte per clock, set by the parse stage, which updates the
// message state, checksum and stored voltage at each byte transfer. The mode
// bit picks 'L' instead of 'W' as plan start letter and should be written only
// while no byte is in flight. After a stall the output holds its result.
module serial_command_parser
  import scp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  event_res,
  output logic [7:0]  data_byte,
  output logic [15:0] voltage_value
);

  logic       logo_mode;
  logic       advance;
  scp_stage_t stage;

  // Plan letter select register.
  always_ff @(posedge clk) begin
    if (rst) begin
      logo_mode <= 1'b0;
    end else if (cfg_we) begin
      logo_mode <= cfg_wdata;
    end
  end

  scp_input_stage u_input (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .rx_byte  (rx_byte),
    .advance  (advance),
    .stage    (stage)
  );

  scp_parse u_parse (
    .clk           (clk),
    .rst           (rst),
    .logo_mode     (logo_mode),
    .stage         (stage),
    .advance       (advance),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .event_res     (event_res),
    .data_byte     (data_byte),
    .voltage_value (voltage_value)
  );

endmodule

// ===== src/scp_checker.sv =====
// Port-level checks of the serial command parser, bound to its top level.
`include "serial_command_parser_defines.svh"

module scp_checker
  import scp_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic [2:0]  event_res,
  input logic [7:0]  data_byte,
  input logic [15:0] voltage_value
);

  // A stalled result keeps every field.
  `SCP_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(event_res) && $stable(data_byte) && $stable(voltage_value), "result changed while stalled")

  // Only data events carry a decoded byte.
  `SCP_ASSERT_SAME(a_data_zero, out_valid && event_res != EV_DATA, data_byte == 8'd0, "data_byte set outside a data event")

  // Event codes stay within the defined set.
  `SCP_ASSERT_SAME(a_event_range, out_valid, event_res <= EV_VOLT, "undefined event code")

  // No result is offered straight after reset.
  `SCP_ASSERT_SAME(a_reset_empty, $past(rst), !out_valid, "result present right after reset")

endmodule

bind serial_command_parser scp_checker u_scp_checker (.*);
